@@ hdl/i2da_pkg.sv @@
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

  localparam int DEF_VALUE_BITS = 31;
  localparam logic [5:0] ASCII_ZERO = 6'd48;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

  // control word broadcast along the chain of digit cells
  typedef struct packed {
    logic clear;   // zero every digit
    logic dabble;  // add-3 adjust, then shift one binary bit in
    logic move;    // shift digits one place toward the top cell
  } i2da_ctrl_t;

endpackage

@@ hdl/i2da_cell.sv @@
// ----------------------------------------------------------------------------
// i2da_cell
// One bcd digit of the conversion chain: add-3 adjust and shift, or digit move.
// ----------------------------------------------------------------------------
module i2da_cell
  import i2da_pkg::*;
(
  input  logic       clk,
  input  i2da_ctrl_t ctrl,
  input  logic       bit_in,
  input  logic [3:0] digit_in,
  output logic       bit_out,
  output logic [3:0] digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  assign adj     = (digit_r >= BCD_ADJ_MIN) ? (digit_r + BCD_ADJ_ADD) : digit_r;
  assign bit_out = adj[3];
  assign digit   = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.move) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

@@ hdl/integer_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts an unsigned integer to ascii decimal digits, most significant first.
// ----------------------------------------------------------------------------
// An accepted word is converted by a double-dabble chain of bcd digit cells,
// one input bit per cycle. The chain holds NDIG digit cells (NDIG = 10 at 31
// bits). The digits are then shifted out of the top cell one per cycle while
// the output side does not stall; leading zeros are dropped without being
// emitted. The block takes no new word until the current one is out; in_ready
// rises again once the final digit has moved into the output register, so the
// next word is taken while that digit still waits. Zero gives a single '0';
// out_last marks the least significant digit.
module integer_to_decimal_ascii
  import i2da_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [5:0]            out_digit_char,
  output logic                  out_last
);

  // decimal digits of 2**VALUE_BITS - 1
  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int CW   = $clog2(VALUE_BITS + 1);
  localparam int RW   = $clog2(NDIG + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } i2da_state_t;

  i2da_state_t           state_r, state_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [CW-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [RW-1:0]         remain_r, remain_nxt;
  logic                  seen_r, seen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [5:0]            out_digit_r, out_digit_nxt;
  logic                  out_last_r, out_last_nxt;

  i2da_ctrl_t            ctrl;
  logic [NDIG-1:0]       carry;
  logic [3:0]            digit [NDIG];
  logic [3:0]            top;
  logic                  skip;
  logic                  fire;

  // chain of digit cells, cell 0 takes the binary msb, cell NDIG-1 is the top
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic       bin;
    logic [3:0] din;
    if (i == 0) begin : g_first
      assign bin = value_r[VALUE_BITS-1];
      assign din = 4'd0;
    end else begin : g_rest
      assign bin = carry[i-1];
      assign din = digit[i-1];
    end
    i2da_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (bin),
      .digit_in (din),
      .bit_out  (carry[i]),
      .digit    (digit[i])
    );
  end

  assign top  = digit[NDIG-1];
  assign skip = (state_r == ST_EMIT) && !seen_r && (top == 4'd0) && (remain_r != RW'(1));
  assign fire = (state_r == ST_EMIT) && !skip && (!out_valid_r || out_ready);

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_digit_r;
  assign out_last       = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    bit_cnt_nxt   = bit_cnt_r;
    remain_nxt    = remain_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          value_nxt   = in_value;
          bit_cnt_nxt = CW'(VALUE_BITS);
          ctrl.clear  = 1'b1;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        value_nxt   = value_r << 1;
        bit_cnt_nxt = bit_cnt_r - CW'(1);
        if (bit_cnt_r == CW'(1)) begin
          remain_nxt = RW'(NDIG);
          seen_nxt   = 1'b0;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip || fire) begin
          ctrl.move  = 1'b1;
          remain_nxt = remain_r - RW'(1);
        end
        if (fire) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = ASCII_ZERO + {2'b00, top};
          out_last_nxt  = (remain_r == RW'(1));
          seen_nxt      = 1'b1;
          if (remain_r == RW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      remain_r    <= '0;
      seen_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      remain_r    <= remain_nxt;
      seen_r      <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  // a shown word is always a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48 && out_digit_char <= 6'd57))
    else $error("digit out of range");

  // the emit phase always has a digit left to send
  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (remain_r != '0))
    else $error("emit with no digits left");

  // a leading digit is never a zero unless it is the only one
  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !seen_r && (remain_r != RW'(1))) |-> (top != 4'd0))
    else $error("leading zero emitted");

  // conversion counter never runs out while bits remain
  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (bit_cnt_r != '0))
    else $error("conversion counter underflow");

endmodule
